// ----- rtl/core/bmfs_pkg.sv -----
// Shared types and constants for the binary masked frame sum block.
// Used by bmfs_lane, bmfs_out and binary_masked_frame_sum; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmfs_pkg;

  localparam int PIX_W      = 32;
  localparam int GROUP_N    = 8;
  localparam int SUM_W      = 64;
  localparam int RES_LIMIT  = 4;     // at most four results per frame
  localparam int POS_W      = 11;    // group position inside a frame
  localparam int WIDX_W     = 9;     // mask word index field
  localparam int WIDE_W     = 13;    // room for frame word counts up to 4096
  localparam int GRP_W      = 15;    // room for group counts up to 16384
  localparam int FW_W       = 10;    // frame_words register
  localparam int AM_W       = 3;     // active_masks register
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WORDS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASKS = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WORDS_RESET  = 10'd512;
  localparam logic [AM_W-1:0] ACTIVE_MASKS_RESET = 3'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef logic [GROUP_N-1:0][PIX_W-1:0] pix_group_t;
  typedef logic [RES_LIMIT-1:0][SUM_W-1:0] sum_bank_t;

  // Control that travels with a pixel group through the lane stages.
  typedef struct packed {
    logic            valid;
    logic            frame_end;
    logic [AM_W-1:0] nm;
    logic [1:0]      shift;
    logic            word_ok;
  } ctl_t;

  // What the top level tells every lane in a cycle.
  typedef struct packed {
    logic            adv;
    logic [1:0]      s1_shift;
    logic            s1_word_ok;
    logic [AM_W-1:0] s1_nm;
    logic            s3_valid;
    logic            s3_end;
  } lane_ctl_t;

  // Hand-off of a finished frame to the result stage.
  typedef struct packed {
    logic            load;
    logic [AM_W-1:0] nm;
  } cap_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmfs_lane.sv -----
// One mask lane: mask word memory, byte select, masked adder tree and 64-bit accumulator.
// Depends on bmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmfs_lane #(
  parameter int LANE_ID         = 0,
  parameter int MAX_FRAME_WORDS = 512,
  parameter int AW              = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [bmfs_pkg::PIX_W-1:0]    wr_data,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  input  wire bmfs_pkg::pix_group_t          pixels,
  input  wire bmfs_pkg::lane_ctl_t           ctl,
  output logic [bmfs_pkg::SUM_W-1:0]         lane_sum
);

  logic [bmfs_pkg::PIX_W-1:0] mem [MAX_FRAME_WORDS];
  logic [bmfs_pkg::PIX_W-1:0] mask_q;
  logic [7:0]                 mask_byte;
  logic                       active;
  bmfs_pkg::pix_group_t       masked;
  logic [3:0][32:0]           pair;
  logic [3:0][32:0]           pair_q;
  logic [34:0]                quad;
  logic [34:0]                quad_q;
  logic [bmfs_pkg::SUM_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mask_q <= mem[rd_addr];
    end
  end

  always_comb begin
    case (ctl.s1_shift)
      2'd0:    mask_byte = mask_q[7:0];
      2'd1:    mask_byte = mask_q[15:8];
      2'd2:    mask_byte = mask_q[23:16];
      2'd3:    mask_byte = mask_q[31:24];
      default: mask_byte = 8'd0;
    endcase
    active = ctl.s1_word_ok && (bmfs_pkg::AM_W'(LANE_ID) < ctl.s1_nm);
    for (int k = 0; k < bmfs_pkg::GROUP_N; k++) begin
      masked[k] = (active && mask_byte[k]) ? pixels[k] : '0;
    end
    for (int j = 0; j < 4; j++) begin
      pair[j] = {1'b0, masked[2*j]} + {1'b0, masked[2*j+1]};
    end
    quad = 35'(pair_q[0]) + 35'(pair_q[1]) + 35'(pair_q[2]) + 35'(pair_q[3]);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pair_q <= pair;
      quad_q <= quad;
    end
  end

  assign lane_sum = acc + bmfs_pkg::SUM_W'(quad_q);

  // The sum restarts from zero once the last group of a frame has been folded in.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.adv && ctl.s3_valid) begin
      acc <= ctl.s3_end ? '0 : lane_sum;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bmfs_out.sv -----
// Result bank: holds the sums of a finished frame and sends them out one beat per mask.
// Depends on bmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmfs_out (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bmfs_pkg::cap_t                cap,
  input  wire bmfs_pkg::sum_bank_t           sums,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         mask_number,
  output logic [bmfs_pkg::SUM_W-1:0]         masked_sum,
  output logic                               last_result
);

  bmfs_pkg::sum_bank_t        bank;
  logic                       busy;
  logic [1:0]                 idx;
  logic [bmfs_pkg::AM_W-1:0]  onum;
  logic                       take;

  assign out_valid   = busy;
  assign mask_number = idx;
  assign masked_sum  = bank[idx];
  assign last_result = ({1'b0, idx} == (onum - bmfs_pkg::AM_W'(1)));
  assign take        = busy && !out_stall;
  // The bank can take a new frame in the same cycle its last beat leaves.
  assign free        = !busy || (take && last_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      onum <= bmfs_pkg::AM_W'(1);
    end else if (cap.load) begin
      busy <= 1'b1;
      idx  <= '0;
      onum <= cap.nm;
    end else if (take) begin
      if (last_result) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap.load) begin
      bank <= sums;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/binary_masked_frame_sum.sv -----
// Top level of the binary masked frame sum: configuration, frame position, lanes, result bank.
// Depends on bmfs_pkg, bmfs_lane and bmfs_out.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid / in_stall    | opcode, mask_select, mask_word_index,
//           |                        | mask_word, pixel_0 .. pixel_7
//   out     | out_valid / out_stall  | mask_number, masked_sum, last_result
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat is taken per cycle while in_stall is low, mask loads and pixel groups alike.
// The first result beat of a frame is presented once its last group has passed ctl1, ctl2
// and ctl3 and its sums have been loaded into the result bank, then one beat per active mask.
// The input stalls only when a frame end reaches the accumulate stage while the result bank
// still drains the previous frame; with out_stall low that never happens, since a frame has
// at least four groups and at most four result beats.
// Reset sets frame_words to 512, active_masks to 1, clears sums and the frame position;
// the mask memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module binary_masked_frame_sum #(
  parameter int MAX_MASKS       = 4,
  parameter int MAX_FRAME_WORDS = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              opcode,
  input  wire logic [1:0]                        mask_select,
  input  wire logic [bmfs_pkg::WIDX_W-1:0]       mask_word_index,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        mask_word,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_0,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_1,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_2,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_3,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_4,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_5,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_6,
  input  wire logic [bmfs_pkg::PIX_W-1:0]        pixel_7,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             mask_number,
  output logic [bmfs_pkg::SUM_W-1:0]             masked_sum,
  output logic                                   last_result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bmfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bmfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LANES = (MAX_MASKS < bmfs_pkg::RES_LIMIT) ? MAX_MASKS : bmfs_pkg::RES_LIMIT;
  localparam int AW    = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;
  localparam logic [bmfs_pkg::WIDE_W-1:0] MAX_FW_W = bmfs_pkg::WIDE_W'(MAX_FRAME_WORDS);
  localparam logic [bmfs_pkg::AM_W-1:0]   LANES_N  = bmfs_pkg::AM_W'(LANES);

  logic [bmfs_pkg::FW_W-1:0]   frame_words;
  logic [bmfs_pkg::AM_W-1:0]   active_masks;
  logic [bmfs_pkg::POS_W-1:0]  pos;
  logic [bmfs_pkg::WIDE_W-1:0] fw_wide;
  logic [bmfs_pkg::WIDE_W-1:0] fw_eff;
  logic [bmfs_pkg::GRP_W-1:0]  groups;
  logic [bmfs_pkg::GRP_W-1:0]  pos_inc;
  logic [bmfs_pkg::AM_W-1:0]   nm_eff;
  logic [bmfs_pkg::WIDE_W-1:0] word_wide;
  logic [bmfs_pkg::WIDE_W-1:0] idx_wide;
  logic                        word_ok;
  logic                        idx_ok;
  logic                        grp_end;
  logic                        accept;
  logic                        pix_accept;
  logic                        load_accept;
  logic                        adv;
  logic                        bank_free;
  bmfs_pkg::ctl_t              ctl_next;
  bmfs_pkg::ctl_t              ctl1;
  bmfs_pkg::ctl_t              ctl2;
  bmfs_pkg::ctl_t              ctl3;
  bmfs_pkg::lane_ctl_t         lane_ctl;
  bmfs_pkg::pix_group_t        pix_q;
  bmfs_pkg::sum_bank_t         sums;
  bmfs_pkg::cap_t              cap;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words  <= bmfs_pkg::FRAME_WORDS_RESET;
      active_masks <= bmfs_pkg::ACTIVE_MASKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmfs_pkg::REG_FRAME_WORDS:  frame_words  <= cfg_data;
        bmfs_pkg::REG_ACTIVE_MASKS: active_masks <= cfg_data[bmfs_pkg::AM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length and mask count, and where the next group falls.
  always_comb begin
    fw_wide = bmfs_pkg::WIDE_W'(frame_words);
    if (fw_wide == '0) begin
      fw_eff = bmfs_pkg::WIDE_W'(1);
    end else if (fw_wide > MAX_FW_W) begin
      fw_eff = MAX_FW_W;
    end else begin
      fw_eff = fw_wide;
    end
    groups  = {fw_eff, 2'b00};
    pos_inc = bmfs_pkg::GRP_W'(pos) + bmfs_pkg::GRP_W'(1);
    grp_end = (pos_inc >= groups);

    if (active_masks == '0) begin
      nm_eff = bmfs_pkg::AM_W'(1);
    end else if (active_masks > LANES_N) begin
      nm_eff = LANES_N;
    end else begin
      nm_eff = active_masks;
    end

    word_wide = bmfs_pkg::WIDE_W'(pos[bmfs_pkg::POS_W-1:2]);
    word_ok   = (word_wide < MAX_FW_W);
    idx_wide  = bmfs_pkg::WIDE_W'(mask_word_index);
    idx_ok    = (idx_wide < MAX_FW_W);
  end

  // Only a finished frame that cannot yet hand off to the result bank holds the pipeline.
  assign adv         = !(ctl3.valid && ctl3.frame_end) || bank_free;
  assign in_stall    = !adv;
  assign accept      = in_valid && !in_stall;
  assign pix_accept  = accept && (opcode == bmfs_pkg::OP_PIXEL);
  assign load_accept = accept && (opcode == bmfs_pkg::OP_LOAD) && idx_ok;

  always_comb begin
    ctl_next.valid     = pix_accept;
    ctl_next.frame_end = grp_end;
    ctl_next.nm        = nm_eff;
    ctl_next.shift     = pos[1:0];
    ctl_next.word_ok   = word_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else if (adv) begin
      ctl1 <= ctl_next;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      if (pix_accept) begin
        pos <= grp_end ? '0 : pos + bmfs_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      pix_q <= {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
    end
  end

  always_comb begin
    lane_ctl.adv        = adv;
    lane_ctl.s1_shift   = ctl1.shift;
    lane_ctl.s1_word_ok = ctl1.word_ok;
    lane_ctl.s1_nm      = ctl1.nm;
    lane_ctl.s3_valid   = ctl3.valid;
    lane_ctl.s3_end     = ctl3.frame_end;
  end

  for (genvar g = 0; g < bmfs_pkg::RES_LIMIT; g++) begin : g_lane
    if (g < LANES) begin : g_on
      bmfs_lane #(
        .LANE_ID        (g),
        .MAX_FRAME_WORDS(MAX_FRAME_WORDS),
        .AW             (AW)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .wr_en   (load_accept && (mask_select == 2'(g))),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data (mask_word),
        .rd_en   (pix_accept && word_ok),
        .rd_addr (word_wide[AW-1:0]),
        .pixels  (pix_q),
        .ctl     (lane_ctl),
        .lane_sum(sums[g])
      );
    end else begin : g_off
      assign sums[g] = '0;
    end
  end

  assign cap.load = adv && ctl3.valid && ctl3.frame_end;
  assign cap.nm   = ctl3.nm;

  bmfs_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cap        (cap),
    .sums       (sums),
    .free       (bank_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mask_number(mask_number),
    .masked_sum (masked_sum),
    .last_result(last_result)
  );

  // A beat that is not the last of its frame is followed by the next mask's beat.
  a_mask_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_result |=>
      out_valid && (mask_number == $past(mask_number) + 2'd1))
    else $error("result beats out of mask order");

  // A finished frame never overwrites a bank that still has beats to send.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl3.valid && ctl3.frame_end && out_valid && !(!out_stall && last_result) |-> in_stall)
    else $error("frame end overran the result bank");

  // A group in the first lane stage always carries a usable mask count.
  a_nm_range: assert property (@(posedge clk) disable iff (rst)
    ctl1.valid |-> (ctl1.nm != '0) && (ctl1.nm <= LANES_N))
    else $error("mask count out of range in pipeline");

  // The first beat after a hand-off is for mask zero.
  a_first_beat: assert property (@(posedge clk) disable iff (rst)
    cap.load |=> out_valid && (mask_number == 2'd0))
    else $error("frame results do not start at mask zero");

endmodule

`default_nettype wire
